/* sv/pip_pkg.sv */
package pip_pkg;

   // Width of each coordinate field in the item
   localparam int FIELD_BITS = 16;
   localparam int REQ_TDATA_BITS = 2 * FIELD_BITS;
   localparam int KIND_BITS = 2;
   localparam int RSP_TDATA_BITS = 8;

   // Item kinds carried on tuser
   localparam logic [KIND_BITS-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FIRST  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_NEXT   = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_FINISH = 2'd3;

   // Result queue
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = RSP_PTR_BITS + 1;

   typedef struct packed {
      logic seg;
      logic start;
      logic finish;
   } op_type;

   typedef struct packed {
      logic on_boundary;
      logic inside_res;
   } res_type;

endpackage

/* sv/point_in_polygon_test.sv */
// A finish item's result goes through the four register stages and the result queue to rsp_.
// Throughput: one item per cycle; the four register stages never stall, and req_tready
// drops only when 8 results (queued plus in flight) are owed to the rsp_ side.
// Reset: synchronous, active high; clears the query point, previous vertex, parity,
// boundary flag, stage ops and the result queue.
module point_in_polygon_test
   import pip_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // [15:0] x_coord, [31:16] y_coord
   input  logic [KIND_BITS-1:0]      req_tuser,   // [1:0] kind
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata    // [0] inside_res, [1] on_boundary, rest zero
);

   // Coordinate width after decoding: a field wider than COORD_BITS is sign-extended
   // from bit COORD_BITS-1; when COORD_BITS exceeds the field, values stay non-negative.
   localparam int VAL_BITS = (COORD_BITS > FIELD_BITS) ? FIELD_BITS + 1 : COORD_BITS;
   localparam int DIF_BITS = VAL_BITS + 1;
   localparam int PRD_BITS = 2 * DIF_BITS;
   localparam int SUM_BITS = PRD_BITS + 1;

   logic signed [VAL_BITS-1:0] in_x, in_y;

   if (COORD_BITS <= FIELD_BITS) begin : g_dec_narrow
      assign in_x = req_tdata[COORD_BITS-1:0];
      assign in_y = req_tdata[FIELD_BITS +: COORD_BITS];
   end else begin : g_dec_wide
      assign in_x = {1'b0, req_tdata[FIELD_BITS-1:0]};
      assign in_y = {1'b0, req_tdata[FIELD_BITS +: FIELD_BITS]};
   end

   logic req_acc;
   logic is_finish_in;
   assign req_acc = req_tvalid && req_tready;
   assign is_finish_in = (req_tuser == KIND_FINISH);

   // ---------------------------------------------------------------
   // Query point and chain tracking, updated at accept
   // ---------------------------------------------------------------
   logic signed [VAL_BITS-1:0] query_x_ff, query_y_ff, prev_x_ff, prev_y_ff;
   logic                       have_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff   <= '0;
         query_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
      end else if (req_acc) begin
         case (req_tuser)
            KIND_START: begin
               query_x_ff   <= in_x;
               query_y_ff   <= in_y;
               have_prev_ff <= 1'b0;
            end
            KIND_FIRST, KIND_NEXT: begin
               prev_x_ff    <= in_x;
               prev_y_ff    <= in_y;
               have_prev_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: segment ends and query point. A next vertex with no
   // previous vertex only opens a chain, so it carries no segment.
   // ---------------------------------------------------------------
   op_type                     s1_op_in, s1_op_ff;
   logic signed [VAL_BITS-1:0] s1_sx_ff, s1_sy_ff, s1_ex_ff, s1_ey_ff, s1_qx_ff, s1_qy_ff;

   always_comb begin
      s1_op_in        = '0;
      s1_op_in.seg    = req_acc && (req_tuser == KIND_NEXT) && have_prev_ff;
      s1_op_in.start  = req_acc && (req_tuser == KIND_START);
      s1_op_in.finish = req_acc && is_finish_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff <= '0;
      end else begin
         s1_op_ff <= s1_op_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sx_ff <= prev_x_ff;
      s1_sy_ff <= prev_y_ff;
      s1_ex_ff <= in_x;
      s1_ey_ff <= in_y;
      s1_qx_ff <= query_x_ff;
      s1_qy_ff <= query_y_ff;
   end

   // ---------------------------------------------------------------
   // Stage 2: edge and point offsets, half-open crossing of y = qy
   // ---------------------------------------------------------------
   logic signed [DIF_BITS-1:0] s1_sx_ext, s1_sy_ext, s1_ex_ext, s1_ey_ext;
   logic signed [DIF_BITS-1:0] s1_qx_ext, s1_qy_ext;
   logic signed [DIF_BITS-1:0] s2_dx_in, s2_dy_in, s2_px_in, s2_py_in;
   logic signed [DIF_BITS-1:0] s2_dx_ff, s2_dy_ff, s2_px_ff, s2_py_ff;
   logic                       s2_cross_in, s2_cross_ff;
   op_type                     s2_op_ff;

   assign s1_sx_ext = DIF_BITS'(s1_sx_ff);
   assign s1_sy_ext = DIF_BITS'(s1_sy_ff);
   assign s1_ex_ext = DIF_BITS'(s1_ex_ff);
   assign s1_ey_ext = DIF_BITS'(s1_ey_ff);
   assign s1_qx_ext = DIF_BITS'(s1_qx_ff);
   assign s1_qy_ext = DIF_BITS'(s1_qy_ff);

   assign s2_dx_in = s1_ex_ext - s1_sx_ext;
   assign s2_dy_in = s1_ey_ext - s1_sy_ext;
   assign s2_px_in = s1_qx_ext - s1_sx_ext;
   assign s2_py_in = s1_qy_ext - s1_sy_ext;
   assign s2_cross_in = ((s1_sy_ff < s1_qy_ff) && (s1_ey_ff >= s1_qy_ff)) ||
                        ((s1_ey_ff < s1_qy_ff) && (s1_sy_ff >= s1_qy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_op_ff <= '0;
      end else begin
         s2_op_ff <= s1_op_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_dx_ff    <= s2_dx_in;
      s2_dy_ff    <= s2_dy_in;
      s2_px_ff    <= s2_px_in;
      s2_py_ff    <= s2_py_in;
      s2_cross_ff <= s2_cross_in;
   end

   // ---------------------------------------------------------------
   // Stage 3: exact products, one multiplier each
   // ---------------------------------------------------------------
   logic signed [PRD_BITS-1:0] s3_pxdx_ff, s3_pydy_ff, s3_dxdx_ff, s3_dydy_ff;
   logic signed [PRD_BITS-1:0] s3_dxpy_ff, s3_dypx_ff;
   logic                       s3_cross_ff, s3_degen_ff, s3_pzero_ff, s3_dypos_ff;
   op_type                     s3_op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_op_ff <= '0;
      end else begin
         s3_op_ff <= s2_op_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_pxdx_ff  <= PRD_BITS'(s2_px_ff) * PRD_BITS'(s2_dx_ff);
      s3_pydy_ff  <= PRD_BITS'(s2_py_ff) * PRD_BITS'(s2_dy_ff);
      s3_dxdx_ff  <= PRD_BITS'(s2_dx_ff) * PRD_BITS'(s2_dx_ff);
      s3_dydy_ff  <= PRD_BITS'(s2_dy_ff) * PRD_BITS'(s2_dy_ff);
      s3_dxpy_ff  <= PRD_BITS'(s2_dx_ff) * PRD_BITS'(s2_py_ff);
      s3_dypx_ff  <= PRD_BITS'(s2_dy_ff) * PRD_BITS'(s2_px_ff);
      s3_cross_ff <= s2_cross_ff;
      s3_degen_ff <= (s2_dx_ff == '0) && (s2_dy_ff == '0);
      s3_pzero_ff <= (s2_px_ff == '0) && (s2_py_ff == '0);
      s3_dypos_ff <= !s2_dy_ff[DIF_BITS-1] && (s2_dy_ff != '0);
   end

   // ---------------------------------------------------------------
   // Stage 4: projection, squared length and cross-product compares
   // ---------------------------------------------------------------
   logic signed [SUM_BITS-1:0] s3_pxdx_ext, s3_pydy_ext, s3_dxdx_ext, s3_dydy_ext;
   logic signed [SUM_BITS-1:0] s4_proj_ff, s4_len2_ff;
   logic                       s4_eq_ff, s4_lt_ff, s4_gt_ff;
   logic                       s4_cross_ff, s4_degen_ff, s4_pzero_ff, s4_dypos_ff;
   op_type                     s4_op_ff;

   assign s3_pxdx_ext = SUM_BITS'(s3_pxdx_ff);
   assign s3_pydy_ext = SUM_BITS'(s3_pydy_ff);
   assign s3_dxdx_ext = SUM_BITS'(s3_dxdx_ff);
   assign s3_dydy_ext = SUM_BITS'(s3_dydy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_op_ff <= '0;
      end else begin
         s4_op_ff <= s3_op_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_proj_ff  <= s3_pxdx_ext + s3_pydy_ext;
      s4_len2_ff  <= s3_dxdx_ext + s3_dydy_ext;
      s4_eq_ff    <= (s3_dxpy_ff == s3_dypx_ff);
      s4_lt_ff    <= (s3_dxpy_ff <  s3_dypx_ff);
      s4_gt_ff    <= (s3_dxpy_ff >  s3_dypx_ff);
      s4_cross_ff <= s3_cross_ff;
      s4_degen_ff <= s3_degen_ff;
      s4_pzero_ff <= s3_pzero_ff;
      s4_dypos_ff <= s3_dypos_ff;
   end

   // ---------------------------------------------------------------
   // Accumulate: a boundary hit is sticky and skips the parity update
   // of that segment; a crossing left of the point toggles parity.
   // ---------------------------------------------------------------
   logic on_seg, toggle;
   logic parity_ff, boundary_ff;

   always_comb begin
      if (s4_degen_ff) begin
         on_seg = s4_pzero_ff;
      end else begin
         on_seg = s4_eq_ff && !s4_proj_ff[SUM_BITS-1] && (s4_proj_ff <= s4_len2_ff);
      end
      toggle = !s4_degen_ff && s4_cross_ff && (s4_dypos_ff ? s4_lt_ff : s4_gt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff   <= 1'b0;
         boundary_ff <= 1'b0;
      end else if (s4_op_ff.start) begin
         parity_ff   <= 1'b0;
         boundary_ff <= 1'b0;
      end else if (s4_op_ff.seg) begin
         if (on_seg) begin
            boundary_ff <= 1'b1;
         end else if (toggle) begin
            parity_ff <= !parity_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result queue. Credit: count finishes accepted but not yet taken
   // on rsp_, and hold req_tready low once the queue could fill.
   // ---------------------------------------------------------------
   res_type                 res_in;
   res_type                 queue_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_BITS-1:0] fill_ff, pending_ff;
   logic                    push, pop, take_finish;

   assign res_in.inside_res  = parity_ff || boundary_ff;
   assign res_in.on_boundary = boundary_ff;
   assign push        = s4_op_ff.finish;
   assign pop         = rsp_tvalid && rsp_tready;
   assign take_finish = req_acc && is_finish_in;

   assign req_tready = (pending_ff < RSP_CNT_BITS'(RSP_DEPTH));
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = {{(RSP_TDATA_BITS - $bits(res_type)){1'b0}}, queue_ff[rd_ptr_ff]};

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         pending_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
         case ({take_finish, pop})
            2'b10:   pending_ff <= pending_ff + 1'b1;
            2'b01:   pending_ff <= pending_ff - 1'b1;
            default: pending_ff <= pending_ff;
         endcase
      end
   end

endmodule

/* sv/pip_checker.sv */
module pip_checker
   import pip_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_TDATA_BITS-1:0] req_tdata,
   input logic [KIND_BITS-1:0]      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   // Results owed: finish items accepted minus results taken
   logic [RSP_CNT_BITS-1:0] owed_ff;
   logic                    fin_acc, rsp_acc;

   assign fin_acc = req_tvalid && req_tready && (req_tuser == KIND_FINISH);
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         case ({fin_acc, rsp_acc})
            2'b10:   owed_ff <= owed_ff + 1'b1;
            2'b01:   owed_ff <= owed_ff - 1'b1;
            default: owed_ff <= owed_ff;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> owed_ff != '0)
      else $error("rsp item with no finish item outstanding");

   a_ready_credit: assert property (@(posedge clock) disable iff (reset)
      owed_ff < RSP_CNT_BITS'(RSP_DEPTH) |-> req_tready)
      else $error("req stalled while result queue has room");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

/* bench/pip_result_checker.sv */
module pip_result_checker
   import pip_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // [15:0] x_coord, [31:16] y_coord
   input  logic [KIND_BITS-1:0]      req_tuser,   // [1:0] kind
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // [0] inside_res, [1] on_boundary, rest zero
   output int                        error_count,
   output int                        results_owed
);

   longint  query_x, query_y, prev_x, prev_y;
   bit      have_prev, parity, boundary_hit;
   res_type expected_flags[$];
   res_type got_flags, want_flags;

   initial begin
      error_count  = 0;
      results_owed = 0;
   end

   function automatic longint coord_value(input logic [FIELD_BITS-1:0] field);
      longint v;
      v = longint'(field) & ((longint'(1) << COORD_BITS) - 1);
      if (v[COORD_BITS-1])
         v = v - (longint'(1) << COORD_BITS);
      return v;
   endfunction

   // Exact on-segment test, then the half-open crossing test; all products fit in 64 bits.
   task automatic trace_segment(input longint sx, input longint sy,
                                input longint ex, input longint ey);
      longint dx, dy, px, py, proj, len2;
      bit     on_seg, left;
      dx = ex - sx;
      dy = ey - sy;
      px = query_x - sx;
      py = query_y - sy;
      if (dx == 0 && dy == 0) begin
         on_seg = (px == 0 && py == 0);
      end else begin
         proj   = px * dx + py * dy;
         len2   = dx * dx + dy * dy;
         on_seg = (dx * py == dy * px) && proj >= 0 && proj <= len2;
      end
      if (on_seg) begin
         boundary_hit = 1'b1;
      end else if ((sy < query_y && ey >= query_y) || (ey < query_y && sy >= query_y)) begin
         left = (dy > 0) ? (py * dx < px * dy) : (py * dx > px * dy);
         if (left)
            parity = ~parity;
      end
   endtask

   task automatic take_item(input logic [KIND_BITS-1:0] kind, input longint x, input longint y);
      res_type flags;
      case (kind)
         KIND_START: begin
            query_x      = x;
            query_y      = y;
            have_prev    = 1'b0;
            parity       = 1'b0;
            boundary_hit = 1'b0;
         end
         KIND_FINISH: begin
            flags.inside_res  = parity | boundary_hit;
            flags.on_boundary = boundary_hit;
            expected_flags.push_back(flags);
         end
         default: begin
            if (kind == KIND_NEXT && have_prev)
               trace_segment(prev_x, prev_y, x, y);
            prev_x    = x;
            prev_y    = y;
            have_prev = 1'b1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         query_x      = 0;
         query_y      = 0;
         prev_x       = 0;
         prev_y       = 0;
         have_prev    = 1'b0;
         parity       = 1'b0;
         boundary_hit = 1'b0;
         expected_flags.delete();
      end else begin
         if (req_tvalid && req_tready)
            take_item(req_tuser, coord_value(req_tdata[FIELD_BITS-1:0]),
                      coord_value(req_tdata[2*FIELD_BITS-1:FIELD_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            got_flags = rsp_tdata[1:0];
            if (expected_flags.size() == 0) begin
               $display("%0t: unexpected result, actual inside_res=%0b on_boundary=%0b",
                        $time, got_flags.inside_res, got_flags.on_boundary);
               error_count++;
            end else begin
               want_flags = expected_flags.pop_front();
               if (got_flags.inside_res !== want_flags.inside_res) begin
                  $display("%0t: inside_res expected %0b actual %0b",
                           $time, want_flags.inside_res, got_flags.inside_res);
                  error_count++;
               end
               if (got_flags.on_boundary !== want_flags.on_boundary) begin
                  $display("%0t: on_boundary expected %0b actual %0b",
                           $time, want_flags.on_boundary, got_flags.on_boundary);
                  error_count++;
               end
               if (rsp_tdata[RSP_TDATA_BITS-1:2] !== '0) begin
                  $display("%0t: padding expected 0 actual %0h",
                           $time, rsp_tdata[RSP_TDATA_BITS-1:2]);
                  error_count++;
               end
            end
         end
      end
      results_owed = expected_flags.size();
   end

endmodule

/* bench/point_in_polygon_test_test.sv */
module point_in_polygon_test_test
   import pip_pkg::*;
();

   // Stop the run when nothing moves on either channel for this many cycles.
   localparam int IDLE_LIMIT   = 2000;
   // Margin to wait once every owed result has been taken.
   localparam int DRAIN_CYCLES = 12;
   localparam int ITEM_TARGET  = 1850;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;   // [15:0] x_coord, [31:16] y_coord
   logic [KIND_BITS-1:0]      req_tuser  = '0;   // [1:0] kind
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;         // [0] inside_res, [1] on_boundary, rest zero

   int error_count;
   int results_owed;
   int req_gap_pct   = 25;
   int rsp_stall_pct = 25;
   int stall_left    = 0;
   int items_sent    = 0;
   int idle_cycles   = 0;

   point_in_polygon_test uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pip_result_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 93)
         return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Coordinate styles: full range toggles every bit, small and medium ranges make
   // shared vertices, horizontal edges and exact hits likely, extremes hit the corners.
   function automatic logic [FIELD_BITS-1:0] rand_coord(input int style);
      int v;
      case (style)
         1: v = int'($urandom_range(0, 40)) - 20;
         2: begin
            case ($urandom_range(0, 6))
               0: v = -32768;
               1: v = -32767;
               2: v = -1;
               3: v = 0;
               4: v = 1;
               5: v = 32766;
               default: v = 32767;
            endcase
         end
         3: v = int'($urandom_range(0, 2000)) - 1000;
         default: v = $urandom;
      endcase
      return v[FIELD_BITS-1:0];
   endfunction

   // Stall the result side at random; hold ready high through stall-free phases.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct)
            stall_left <= pick_gap();
      end
   end

   // Watchdog: count cycles with no item moving on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drive one item from a falling edge and hold it until accepted. Keep valid high
   // between back-to-back items; drop it only when a gap is taken.
   task automatic send_item(input logic [KIND_BITS-1:0] kind,
                            input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y);
      int gap;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // One query: build the chains first so the query point can be placed on a vertex,
   // between two vertices or on a vertex's horizontal line, then stream it all out.
   task automatic run_polygon();
      logic [FIELD_BITS-1:0] vx[$], vy[$];
      bit                    chain_head[$];
      logic [FIELD_BITS-1:0] qx, qy;
      logic [KIND_BITS-1:0]  kind;
      int                    style, chains, nverts, base, pick, sel, a, b;
      sel = $urandom_range(0, 9);
      style = (sel < 5) ? 1 : (sel < 7) ? 3 : (sel < 8) ? 2 : 0;
      chains = $urandom_range(1, 3);
      for (int c = 0; c < chains; c++) begin
         nverts = $urandom_range(2, 7);
         base   = vx.size();
         for (int k = 0; k < nverts; k++) begin
            vx.push_back(rand_coord(($urandom_range(0, 9) == 0) ? 2 : style));
            vy.push_back(rand_coord(($urandom_range(0, 9) == 0) ? 2 : style));
            chain_head.push_back(k == 0);
         end
         // close most chains back onto their first vertex; leave some open
         if ($urandom_range(0, 9) < 8) begin
            vx.push_back(vx[base]);
            vy.push_back(vy[base]);
            chain_head.push_back(1'b0);
         end
      end
      pick = $urandom_range(0, vx.size() - 2);
      case ($urandom_range(0, 9))
         0, 1: begin
            qx = vx[pick];
            qy = vy[pick];
         end
         2, 3: begin
            a  = int'($signed(vx[pick])) + int'($signed(vx[pick + 1]));
            b  = int'($signed(vy[pick])) + int'($signed(vy[pick + 1]));
            a  = a >>> 1;
            b  = b >>> 1;
            qx = a[FIELD_BITS-1:0];
            qy = b[FIELD_BITS-1:0];
         end
         4: begin
            qx = rand_coord(style);
            qy = vy[pick];
         end
         default: begin
            qx = rand_coord(style);
            qy = rand_coord(style);
         end
      endcase
      send_item(KIND_START, qx, qy);
      for (int i = 0; i < vx.size(); i++) begin
         kind = chain_head[i] ? KIND_FIRST : KIND_NEXT;
         // break a few sequences: open a chain with a next-vertex item
         if (chain_head[i] && $urandom_range(0, 19) == 0)
            kind = KIND_NEXT;
         send_item(kind, vx[i], vy[i]);
      end
      send_item(KIND_FINISH, rand_coord(0), rand_coord(0));
      // a repeated finish must repeat the answer
      if ($urandom_range(0, 99) < 15)
         send_item(KIND_FINISH, rand_coord(0), rand_coord(0));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Finish before any start reports on the reset query point.
      send_item(KIND_FINISH, 16'h1234, 16'h8765);

      // Next vertex with no chain open acts as a first vertex; the full-range
      // diagonal then passes exactly through the query point. Finish twice.
      send_item(KIND_START, 16'h0000, 16'h0000);
      send_item(KIND_NEXT, 16'h8000, 16'h8000);
      send_item(KIND_NEXT, 16'h7FFF, 16'h7FFF);
      send_item(KIND_FINISH, 16'h0000, 16'h0000);
      send_item(KIND_FINISH, 16'hFFFF, 16'hFFFF);

      // Degenerate segment sitting on the query point.
      send_item(KIND_START, 16'h0005, 16'h0005);
      send_item(KIND_FIRST, 16'h0005, 16'h0005);
      send_item(KIND_NEXT, 16'h0005, 16'h0005);
      send_item(KIND_FINISH, 16'h0000, 16'h0000);

      // Small closed square around the origin: strictly inside.
      send_item(KIND_START, 16'h0000, 16'h0000);
      send_item(KIND_FIRST, 16'hFFF6, 16'hFFF6);
      send_item(KIND_NEXT, 16'h000A, 16'hFFF6);
      send_item(KIND_NEXT, 16'h000A, 16'h000A);
      send_item(KIND_NEXT, 16'hFFF6, 16'h000A);
      send_item(KIND_NEXT, 16'hFFF6, 16'hFFF6);
      send_item(KIND_FINISH, 16'h0000, 16'h0000);

      // Full-range square with the query one step inside its left edge.
      send_item(KIND_START, 16'h8001, 16'h0000);
      send_item(KIND_FIRST, 16'h8000, 16'h8000);
      send_item(KIND_NEXT, 16'h7FFF, 16'h8000);
      send_item(KIND_NEXT, 16'h7FFF, 16'h7FFF);
      send_item(KIND_NEXT, 16'h8000, 16'h7FFF);
      send_item(KIND_NEXT, 16'h8000, 16'h8000);
      send_item(KIND_FINISH, 16'h0000, 16'h0000);

      // Random queries; pick the pacing per query so some run with no idling at all.
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
            2, 3: begin
               req_gap_pct   = 60;
               rsp_stall_pct = 50;
            end
            default: begin
               req_gap_pct   = 25;
               rsp_stall_pct = 25;
            end
         endcase
         // noise: a few items of any kind with any coordinates
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
               send_item(KIND_BITS'($urandom_range(0, 3)), rand_coord(0), rand_coord(0));
         end
         run_polygon();
      end

      // Drain: drop valid, wait for every owed result, then a latency margin.
      req_tvalid <= 1'b0;
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
sv/pip_pkg.sv
sv/point_in_polygon_test.sv
sv/pip_checker.sv
bench/pip_result_checker.sv
bench/point_in_polygon_test_test.sv
